// ----- rtl/core/rgb_to_hsv_convert_top_assert.svh -----
// Assertion macros shared by the RGB to HSV conversion RTL.
`ifndef RGB_TO_HSV_CONVERT_TOP_ASSERT_SVH
`define RGB_TO_HSV_CONVERT_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define RHC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rgb_to_hsv_convert_top: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define RHC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rgb_to_hsv_convert_top: next-cycle check failed");

`endif

// ----- rtl/core/rhc_pkg.sv -----
// Package of types and constants for the RGB to HSV conversion.
package rhc_pkg;

   // Hue is 9.6 fixed point degrees.
   localparam int HUE_BITS   = 15;
   // Quotient bits of one sector span: at most 60 degrees = 3840.
   localparam int HUE_Q_BITS = 12;

   localparam logic [HUE_BITS-1:0] SECTOR_SPAN   = 15'd3840;
   localparam logic [HUE_BITS-1:0] HUE_DEG_120   = 15'd7680;
   localparam logic [HUE_BITS-1:0] HUE_DEG_240   = 15'd15360;
   localparam logic [HUE_BITS-1:0] HUE_FULL_TURN = 15'd23040;

   // Which channel is largest, and for red which side of zero degrees.
   typedef enum logic [1:0] {
      SECTOR_RED_LOW  = 2'd0,
      SECTOR_GREEN    = 2'd1,
      SECTOR_BLUE     = 2'd2,
      SECTOR_RED_HIGH = 2'd3
   } sector_type;

   function automatic logic [HUE_BITS-1:0] sector_base(input sector_type sector);
      logic [HUE_BITS-1:0] base;
      case (sector)
         SECTOR_RED_LOW:  base = '0;
         SECTOR_GREEN:    base = HUE_DEG_120;
         SECTOR_BLUE:     base = HUE_DEG_240;
         SECTOR_RED_HIGH: base = HUE_FULL_TURN;
         default:         base = '0;
      endcase
      return base;
   endfunction

endpackage

// ----- rtl/core/rhc_if.sv -----
// Valid/ready channel interfaces for RGB pixels and HSV results.
interface rhc_pix_if #(parameter int CHANNEL_BITS = 8);
   logic                    valid;
   logic                    ready;
   logic [CHANNEL_BITS-1:0] red;
   logic [CHANNEL_BITS-1:0] green;
   logic [CHANNEL_BITS-1:0] blue;

   modport source (output valid, red, green, blue, input ready);
   modport sink   (input valid, red, green, blue, output ready);
endinterface

interface rhc_hsv_if #(parameter int CHANNEL_BITS = 8);
   import rhc_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [HUE_BITS-1:0]     hue;
   logic [CHANNEL_BITS-1:0] saturation;
   logic [CHANNEL_BITS-1:0] brightness;

   modport source (output valid, hue, saturation, brightness, input ready);
   modport sink   (input valid, hue, saturation, brightness, output ready);
endinterface

// ----- rtl/core/rgb_to_hsv_convert_top.sv -----
// Pipelined RGB to HSV pixel converter, top level.
//
// Use: drive pixels on req_pix (red, green, blue) with valid/ready; an item
// moves at every rising edge where valid and ready are both high. Results
// leave on rsp_hsv as hue (degrees, 6 fraction bits), saturation (0..full
// scale, floor) and brightness (largest channel), in input order.
// DIV_STAGES = max(12, CHANNEL_BITS). One item per cycle is sustained while
// rsp_hsv.ready stays high.
// Pipeline: one stage picks the largest channel and the chroma, one forms
// both dividends, then DIV_STAGES restoring-division stages retire one
// quotient bit each for hue and saturation side by side, then the output
// register forms the final hue. The division depth sets the latency.
// Stall: each stage moves when it is empty or its successor moves, so a
// stalled rsp_hsv fills bubbles first and drops req_pix.ready only when
// every stage holds an item. Nothing is lost or repeated.
// Reset (synchronous, active high) clears every valid bit; the datapath
// needs no clearing and no item is held over.
module rgb_to_hsv_convert_top #(
   parameter int CHANNEL_BITS = 8
) (
   input logic       clock,
   input logic       reset,
   rhc_pix_if.sink   req_pix,
   rhc_hsv_if.source rsp_hsv
);
   import rhc_pkg::*;

   `include "rgb_to_hsv_convert_top_assert.svh"

   localparam int CB         = CHANNEL_BITS;
   localparam int DIV_STAGES = (CB > HUE_Q_BITS) ? CB : HUE_Q_BITS;
   localparam int DW         = CB + DIV_STAGES;

   typedef struct packed {
      logic [DW-1:0]         rem_hue;
      logic [DW-1:0]         rem_sat;
      logic [DIV_STAGES-1:0] quo_hue;
      logic [DIV_STAGES-1:0] quo_sat;
      logic [CB-1:0]         den;
      logic [CB-1:0]         mx;
      sector_type            sector;
      logic                  neg;
   } div_stage_type;

   // ---------------- handshake: stage moves if empty or successor moves
   logic                  v_f1_ff;
   logic [DIV_STAGES:0]   v_div_ff;
   logic [DIV_STAGES:0]   v_div_in;
   logic                  v_out_ff;
   logic                  rdy_f1;
   logic [DIV_STAGES:0]   rdy_div;
   logic                  rdy_out;

   always_comb begin
      rdy_out = !v_out_ff || rsp_hsv.ready;
      rdy_div[DIV_STAGES] = !v_div_ff[DIV_STAGES] || rdy_out;
      for (int i = DIV_STAGES - 1; i >= 0; i--) begin
         rdy_div[i] = !v_div_ff[i] || rdy_div[i+1];
      end
      rdy_f1 = !v_f1_ff || rdy_div[0];
   end

   assign req_pix.ready = rdy_f1;

   always_comb begin
      v_div_in = v_div_ff;
      if (rdy_div[0]) begin
         v_div_in[0] = v_f1_ff;
      end
      for (int i = 1; i <= DIV_STAGES; i++) begin
         if (rdy_div[i]) begin
            v_div_in[i] = v_div_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_f1_ff  <= 1'b0;
         v_div_ff <= '0;
         v_out_ff <= 1'b0;
      end else begin
         if (rdy_f1) begin
            v_f1_ff <= req_pix.valid;
         end
         v_div_ff <= v_div_in;
         if (rdy_out) begin
            v_out_ff <= v_div_ff[DIV_STAGES];
         end
      end
   end

   // ---------------- front stage: largest channel, chroma, hue numerator
   logic [CB-1:0] f1_mx_ff,  f1_mx_in;
   logic [CB-1:0] f1_den_ff, f1_den_in;
   logic [CB-1:0] f1_num_ff, f1_num_in;
   sector_type    f1_sector_ff, f1_sector_in;
   logic          f1_neg_ff, f1_neg_in;

   always_comb begin
      logic [CB-1:0] r, g, b;
      logic [CB-1:0] d_br, d_rg, d_gb;
      logic [CB-1:0] mn;
      r = req_pix.red;
      g = req_pix.green;
      b = req_pix.blue;
      // Absolute channel differences, all in parallel.
      d_br = (b >= r) ? b - r : r - b;
      d_rg = (r >= g) ? r - g : g - r;
      d_gb = (g >= b) ? g - b : b - g;
      // Green wins ties, then blue, then red.
      if (g >= r && g >= b) begin
         f1_mx_in     = g;
         mn           = (r < b) ? r : b;
         f1_sector_in = SECTOR_GREEN;
         f1_neg_in    = (b < r);
         f1_num_in    = d_br;
      end else if (b >= g && b >= r) begin
         f1_mx_in     = b;
         mn           = (r < g) ? r : g;
         f1_sector_in = SECTOR_BLUE;
         f1_neg_in    = (r < g);
         f1_num_in    = d_rg;
      end else if (g >= b) begin
         f1_mx_in     = r;
         mn           = b;
         f1_sector_in = SECTOR_RED_LOW;
         f1_neg_in    = 1'b0;
         f1_num_in    = d_gb;
      end else begin
         f1_mx_in     = r;
         mn           = g;
         f1_sector_in = SECTOR_RED_HIGH;
         f1_neg_in    = 1'b1;
         f1_num_in    = d_gb;
      end
      f1_den_in = f1_mx_in - mn;
   end

   always_ff @(posedge clock) begin
      if (rdy_f1) begin
         f1_mx_ff     <= f1_mx_in;
         f1_den_ff    <= f1_den_in;
         f1_num_ff    <= f1_num_in;
         f1_sector_ff <= f1_sector_in;
         f1_neg_ff    <= f1_neg_in;
      end
   end

   // ---------------- dividend stage and division stages
   div_stage_type div_ff [DIV_STAGES+1];
   div_stage_type div_in [DIV_STAGES+1];
   div_stage_type div0_in;

   always_comb begin
      div0_in.rem_hue = DW'(f1_num_ff) * DW'(SECTOR_SPAN);
      // full scale times chroma: (den << CB) - den
      div0_in.rem_sat = (DW'(f1_den_ff) << CB) - DW'(f1_den_ff);
      div0_in.quo_hue = '0;
      div0_in.quo_sat = '0;
      div0_in.den     = f1_den_ff;
      div0_in.mx      = f1_mx_ff;
      div0_in.sector  = f1_sector_ff;
      div0_in.neg     = f1_neg_ff;
   end

   assign div_in[0] = div0_in;

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
      localparam int QBIT = DIV_STAGES - 1 - k;
      div_stage_type step_in;

      // Retire quotient bit QBIT of both divisions.
      always_comb begin
         logic [DW-1:0] sub_hue, sub_sat;
         sub_hue = DW'(div_ff[k].den) << QBIT;
         sub_sat = DW'(div_ff[k].mx) << QBIT;
         step_in = div_ff[k];
         if (div_ff[k].rem_hue >= sub_hue) begin
            step_in.rem_hue       = div_ff[k].rem_hue - sub_hue;
            step_in.quo_hue[QBIT] = 1'b1;
         end
         if (div_ff[k].rem_sat >= sub_sat) begin
            step_in.rem_sat       = div_ff[k].rem_sat - sub_sat;
            step_in.quo_sat[QBIT] = 1'b1;
         end
      end

      assign div_in[k+1] = step_in;
   end

   // Advance each division stage when it may move; hold it otherwise.
   always_ff @(posedge clock) begin
      for (int i = 0; i <= DIV_STAGES; i++) begin
         if (rdy_div[i]) begin
            div_ff[i] <= div_in[i];
         end
      end
   end

   // ---------------- output register: sector offset and special cases
   logic [HUE_BITS-1:0] hue_ff, hue_in;
   logic [CB-1:0]       sat_ff, sat_in;
   logic [CB-1:0]       bright_ff;

   always_comb begin
      logic [HUE_BITS-1:0] base, quo;
      base = sector_base(div_ff[DIV_STAGES].sector);
      quo  = HUE_BITS'(div_ff[DIV_STAGES].quo_hue[HUE_Q_BITS-1:0]);
      // Grey pixel: no chroma, hue is zero.
      if (div_ff[DIV_STAGES].den == '0) begin
         hue_in = '0;
      end else if (div_ff[DIV_STAGES].neg) begin
         hue_in = base - quo;
      end else begin
         hue_in = base + quo;
      end
      // Black pixel: saturation is zero.
      sat_in = (div_ff[DIV_STAGES].mx == '0) ? '0 : div_ff[DIV_STAGES].quo_sat[CB-1:0];
   end

   always_ff @(posedge clock) begin
      if (rdy_out) begin
         hue_ff    <= hue_in;
         sat_ff    <= sat_in;
         bright_ff <= div_ff[DIV_STAGES].mx;
      end
   end

   assign rsp_hsv.valid      = v_out_ff;
   assign rsp_hsv.hue        = hue_ff;
   assign rsp_hsv.saturation = sat_ff;
   assign rsp_hsv.brightness = bright_ff;

   // ---------------- assertions
   `RHC_ASSERT_IMPLY(a_no_chroma_no_hue, clock, reset, rsp_hsv.valid && (rsp_hsv.saturation == '0), rsp_hsv.hue == '0)
   `RHC_ASSERT_IMPLY(a_hue_in_turn, clock, reset, rsp_hsv.valid, rsp_hsv.hue <= HUE_FULL_TURN)
   `RHC_ASSERT_NEXT(a_item_enters, clock, reset, req_pix.valid && req_pix.ready, v_f1_ff)
   `RHC_ASSERT_NEXT(a_last_div_holds, clock, reset, v_div_ff[DIV_STAGES] && !rdy_out, v_div_ff[DIV_STAGES] && $stable(div_ff[DIV_STAGES]))

endmodule

// ----- test/rgb_to_hsv_convert_top_tb.sv -----
// Testbench for the RGB to HSV pixel converter: predicted results checked in order.
module rgb_to_hsv_convert_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rhc_pkg::*;

   localparam int CHANNEL_BITS = 8;
   localparam int CHAN_FULL    = (1 << CHANNEL_BITS) - 1;
   // Accept-to-result latency of the converter; sizes the final drain wait.
   localparam int PIPE_LATENCY = 14;
   // Longest correct quiet stretch is the long receiver hold-off below.
   localparam int HOLD_CYCLES  = 400;
   localparam int QUIET_LIMIT  = 5 * HOLD_CYCLES;

   typedef logic [CHANNEL_BITS-1:0] chan_type;

   typedef struct packed {
      logic [HUE_BITS-1:0] hue;
      chan_type            saturation;
      chan_type            brightness;
   } hsv_pixel_type;

   typedef enum logic [1:0] {
      RX_ALWAYS_READY,
      RX_RANDOM_STALL
   } rx_mode_type;

   logic clock = 1'b0;
   logic reset;

   rhc_pix_if #(.CHANNEL_BITS(CHANNEL_BITS)) pix ();
   rhc_hsv_if #(.CHANNEL_BITS(CHANNEL_BITS)) hsv ();

   rgb_to_hsv_convert_top #(.CHANNEL_BITS(CHANNEL_BITS)) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_pix (pix.sink),
      .rsp_hsv (hsv.source)
   );

   always #4 clock = ~clock;

   // HSV results predicted for accepted pixels, oldest first.
   hsv_pixel_type pending_hsv[$];
   int            error_count  = 0;
   int            quiet_cycles = 0;

   // Sender pacing: bursts of random length separated by random gaps.
   bit sender_bursty = 1'b0;
   int burst_left    = 0;

   // Receiver pacing; toggling hold_trigger asks for one long hold-off.
   rx_mode_type rx_mode      = RX_ALWAYS_READY;
   logic        hold_trigger = 1'b0;

   // ---------------------------------------------------------------
   // Predictor: largest channel with green tested first, then blue,
   // then red split on whether green is at least blue.
   // ---------------------------------------------------------------
   function automatic hsv_pixel_type predict_hsv(input chan_type r, input chan_type g,
                                                 input chan_type b);
      sector_type    sector;
      int unsigned   ri;
      int unsigned   gi;
      int unsigned   bi;
      int unsigned   top_chan;
      int unsigned   low_chan;
      int unsigned   diff;
      int unsigned   chroma;
      int unsigned   base;
      int unsigned   quot;
      bit            below_base;
      hsv_pixel_type res;
      ri = 32'(r);
      gi = 32'(g);
      bi = 32'(b);
      if (gi >= ri && gi >= bi) begin
         sector     = SECTOR_GREEN;
         top_chan   = gi;
         low_chan   = (ri < bi) ? ri : bi;
         below_base = (ri > bi);
         diff       = below_base ? (ri - bi) : (bi - ri);
      end else if (bi >= gi && bi >= ri) begin
         // min of red and green in the blue branch
         sector     = SECTOR_BLUE;
         top_chan   = bi;
         low_chan   = (ri < gi) ? ri : gi;
         below_base = (gi > ri);
         diff       = below_base ? (gi - ri) : (ri - gi);
      end else if (gi >= bi) begin
         sector     = SECTOR_RED_LOW;
         top_chan   = ri;
         low_chan   = bi;
         below_base = 1'b0;
         diff       = gi - bi;
      end else begin
         // count down from a full turn so hue stays below 360 degrees
         sector     = SECTOR_RED_HIGH;
         top_chan   = ri;
         low_chan   = gi;
         below_base = 1'b1;
         diff       = bi - gi;
      end
      case (sector)
         SECTOR_GREEN:    base = 32'(HUE_DEG_120);
         SECTOR_BLUE:     base = 32'(HUE_DEG_240);
         SECTOR_RED_HIGH: base = 32'(HUE_FULL_TURN);
         default:         base = 0;
      endcase
      chroma = top_chan - low_chan;
      if (chroma == 0) begin
         res.hue = '0;
      end else begin
         quot    = (int'(SECTOR_SPAN) * diff) / chroma;
         res.hue = HUE_BITS'(below_base ? base - quot : base + quot);
      end
      res.saturation = (top_chan == 0) ? '0 : chan_type'((CHAN_FULL * chroma) / top_chan);
      res.brightness = chan_type'(top_chan);
      return res;
   endfunction

   // ---------------------------------------------------------------
   // Offer one pixel, hold it until accepted, then queue its result.
   // ---------------------------------------------------------------
   task automatic send_pixel(input chan_type r, input chan_type g, input chan_type b);
      int gap;
      pix.valid <= 1'b1;
      pix.red   <= r;
      pix.green <= g;
      pix.blue  <= b;
      do @(posedge clock); while (!(pix.valid && pix.ready));
      pending_hsv.push_back(predict_hsv(r, g, b));
      if (sender_bursty) begin
         if (burst_left == 0) begin
            // drop valid for a random gap, then start a new burst
            gap        = $urandom_range(1, 12);
            burst_left = $urandom_range(1, 30);
            pix.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end else begin
            burst_left--;
         end
      end
   endtask

   // Pixel mix biased toward ties, greys and extremes, where the sector
   // choice and the division are most fragile.
   task automatic send_random_pixel();
      chan_type r, g, b, base;
      int       kind;
      kind = $urandom_range(0, 9);
      r = chan_type'($urandom);
      g = chan_type'($urandom);
      b = chan_type'($urandom);
      case (kind)
         5: begin
            // two channels tie for the maximum
            base = chan_type'($urandom_range(1, CHAN_FULL));
            case ($urandom_range(0, 2))
               0: begin
                  r = base; g = base; b = chan_type'($urandom_range(0, 32'(base)));
               end
               1: begin
                  g = base; b = base; r = chan_type'($urandom_range(0, 32'(base)));
               end
               default: begin
                  r = base; b = base; g = chan_type'($urandom_range(0, 32'(base)));
               end
            endcase
         end
         6: begin
            // near grey: tiny chroma
            base = chan_type'($urandom_range(0, CHAN_FULL - 3));
            r = chan_type'(32'(base) + $urandom_range(0, 3));
            g = chan_type'(32'(base) + $urandom_range(0, 3));
            b = chan_type'(32'(base) + $urandom_range(0, 3));
         end
         7: begin
            // red and green at the rails, blue mostly at full scale
            r = $urandom_range(0, 1) ? chan_type'(CHAN_FULL) : '0;
            g = $urandom_range(0, 1) ? chan_type'(CHAN_FULL) : '0;
            b = $urandom_range(0, 2) == 0 ? chan_type'($urandom) : chan_type'(CHAN_FULL);
         end
         8: begin
            case ($urandom_range(0, 2))
               0:       r = '0;
               1:       g = '0;
               default: b = '0;
            endcase
         end
         9: begin
            base = chan_type'($urandom);
            r = base; g = base; b = base;
         end
         default: ;
      endcase
      send_pixel(r, g, b);
   endtask

   // ---------------------------------------------------------------
   // Receiver: ready pattern of its own, plus the long hold-off.
   // ---------------------------------------------------------------
   always @(posedge clock) begin : rx_pacing
      static int   run_left  = 0;
      static int   hold_left = 0;
      static logic hold_seen = 1'b0;
      static logic ready_val = 1'b1;
      if (hold_trigger != hold_seen) begin
         hold_seen = hold_trigger;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         ready_val = 1'b0;
      end else if (rx_mode == RX_ALWAYS_READY) begin
         ready_val = 1'b1;
      end else if (run_left > 0) begin
         run_left--;
      end else begin
         ready_val = ($urandom_range(0, 9) < 7);
         run_left  = ready_val ? $urandom_range(0, 20) : $urandom_range(0, 8);
      end
      hsv.ready <= ready_val;
   end

   // ---------------------------------------------------------------
   // Result checker: compare each accepted result with the oldest
   // prediction, field by field.
   // ---------------------------------------------------------------
   always @(posedge clock) begin : hsv_check
      hsv_pixel_type want;
      if (!reset && hsv.valid && hsv.ready) begin
         if (pending_hsv.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result hue=%0d sat=%0d val=%0d", $realtime,
                     hsv.hue, hsv.saturation, hsv.brightness);
         end else begin
            want = pending_hsv.pop_front();
            if (hsv.hue !== want.hue) begin
               error_count++;
               $display("%0t: hue mismatch expected %0d actual %0d", $realtime,
                        want.hue, hsv.hue);
            end
            if (hsv.saturation !== want.saturation) begin
               error_count++;
               $display("%0t: saturation mismatch expected %0d actual %0d", $realtime,
                        want.saturation, hsv.saturation);
            end
            if (hsv.brightness !== want.brightness) begin
               error_count++;
               $display("%0t: brightness mismatch expected %0d actual %0d", $realtime,
                        want.brightness, hsv.brightness);
            end
         end
      end
   end

   // Count cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if ((pix.valid && pix.ready) || (hsv.valid && hsv.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin : watchdog
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("DONE: errors detected");
      $finish;
   end

   // ---------------------------------------------------------------
   // Test tasks
   // ---------------------------------------------------------------

   // Primaries, secondaries, black, white and the rails of each field.
   task automatic test_extremes();
      sender_bursty = 1'b0;
      rx_mode       = RX_ALWAYS_READY;
      send_pixel(8'd0,   8'd0,   8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0,   8'd0);
      send_pixel(8'd0,   8'd255, 8'd0);
      send_pixel(8'd0,   8'd0,   8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0,   8'd255, 8'd255);
      send_pixel(8'd255, 8'd0,   8'd255);
      send_pixel(8'd1,   8'd0,   8'd0);
      send_pixel(8'd0,   8'd1,   8'd0);
      send_pixel(8'd0,   8'd0,   8'd1);
   endtask

   // Grey, ties between channels, both red sub-sectors and small chroma.
   task automatic test_special_cases();
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd200, 8'd200, 8'd100);
      send_pixel(8'd100, 8'd200, 8'd200);
      send_pixel(8'd200, 8'd100, 8'd200);
      send_pixel(8'd255, 8'd1,   8'd0);
      send_pixel(8'd255, 8'd0,   8'd1);
      send_pixel(8'd255, 8'd0,   8'd254);
      send_pixel(8'd255, 8'd254, 8'd254);
      send_pixel(8'd170, 8'd85,  8'd10);
      send_pixel(8'd10,  8'd85,  8'd170);
      send_pixel(8'd85,  8'd10,  8'd170);
      send_pixel(8'd1,   8'd2,   8'd3);
   endtask

   // Back-to-back pixels with the receiver always ready.
   task automatic test_full_rate_stream();
      sender_bursty = 1'b0;
      rx_mode       = RX_ALWAYS_READY;
      repeat (400) send_random_pixel();
   endtask

   // Bursty sender against a randomly stalling receiver.
   task automatic test_random_pacing();
      sender_bursty = 1'b1;
      burst_left    = 0;
      rx_mode       = RX_RANDOM_STALL;
      repeat (600) send_random_pixel();
   endtask

   // Hold the receiver off long enough for the pipeline to fill and
   // stall the input while the sender keeps offering pixels.
   task automatic test_output_backpressure();
      sender_bursty = 1'b0;
      rx_mode       = RX_ALWAYS_READY;
      hold_trigger  = ~hold_trigger;
      repeat (200) send_random_pixel();
   endtask

   // Mixed pacing once more after the hold-off.
   task automatic test_mixed_tail();
      sender_bursty = 1'b1;
      burst_left    = 0;
      rx_mode       = RX_RANDOM_STALL;
      repeat (200) send_random_pixel();
   endtask

   // ---------------------------------------------------------------
   // Run sequence
   // ---------------------------------------------------------------
   initial begin : run_tests
      reset      = 1'b1;
      pix.valid  = 1'b0;
      pix.red    = '0;
      pix.green  = '0;
      pix.blue   = '0;
      hsv.ready  = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extremes();
      test_special_cases();
      test_full_rate_stream();
      test_random_pacing();
      test_output_backpressure();
      test_mixed_tail();

      // Drop valid, let the receiver drain, then allow time for strays.
      pix.valid    <= 1'b0;
      sender_bursty = 1'b0;
      rx_mode       = RX_ALWAYS_READY;
      while (pending_hsv.size() != 0) @(posedge clock);
      repeat (3 * PIPE_LATENCY) @(posedge clock);

      if (error_count == 0 && pending_hsv.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
